// ----- hw/rtl/kdk_pkg.sv -----
// kdk_pkg: shared types, codes and default sizes for the kd-tree k-nearest search block
// no dependencies; used by the top level under hw/rtl and by the files under dv

package kdk_pkg;

    // default sizes, overridable on the top level
    localparam int DEF_MAX_POINTS     = 1024;
    localparam int DEF_MAX_NEIGHBOURS = 32;
    localparam int DEF_COORD_BITS     = 16;

    // fixed field widths of the beats
    localparam int FIELD_W     = 16;
    localparam int DIST_OUT_W  = 34;
    localparam int COUNT_OUT_W = 6;

    // split axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    // progress of one suspended tree node
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DONE
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NODE,
        S_NODE_RD,
        S_GAP,
        S_RESUME,
        S_DRD,
        S_D0,
        S_D1,
        S_D2,
        S_D3,
        S_HIT,
        S_MH_INIT,
        S_MH_SUB,
        S_MH_V,
        S_SF_L,
        S_SF_R,
        S_SF_C,
        S_SF_END,
        S_TOPRD,
        S_TOP,
        S_EMIT,
        S_EM_NONE,
        S_EM_RD,
        S_EM_LD
    } state_t;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [FIELD_W-1:0]    x_coord;
        logic signed [FIELD_W-1:0]    y_coord;
        logic signed [FIELD_W-1:0]    z_coord;
        logic [FIELD_W-1:0]           point_id;
        logic [COUNT_OUT_W-1:0]       want_count;
        logic [DIST_OUT_W-1:0]        search_radius_sq;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0]           neighbour_id;
        logic [DIST_OUT_W-1:0]        distance_sq;
        logic [DIST_OUT_W-1:0]        final_radius_sq;
        logic [COUNT_OUT_W-1:0]       found_total;
        logic                         none_found;
        logic                         last_result;
    } rsp_t;

endpackage

// ----- hw/rtl/kd_tree_k_nearest_search.sv -----
// kd_tree_k_nearest_search: k-nearest search over a 3d implicit kd-tree, top level
// depends on kdk_pkg, kdk_ram, kdk_sq_unit and kdk_split

// Points are appended in implicit kd-tree order (node, left subtree, right
// subtree) and a query walks the tree depth first with x, y, z split axes,
// keeping up to want_count hits strictly inside the squared radius in a
// max-heap. One command beat is taken at a time and cmd_stall stays high until
// the query's walk and heap work are done and its last result is loaded into
// the output register. A query opens each split node with a point read, the
// shared squarer, a stack push and three resume steps, and tests that node's
// own distance once its subtrees are done (point reread, three passes through
// the single squarer, hit check); a leaf gets the read and test only. Each
// heap insert or build step reads and compares children on every heap level
// (one heap memory read port), then writes back and reloads the heap top; an
// emit step follows, then a heap read and an output load per result, the load
// waiting while the result side stalls; the point memory and the one squarer
// set the pace. Results come out in heap array order, each carrying the final
// squared radius and the hit count; a query without hits gives one beat with
// none_found and last_result set and all other fields zero.

module kd_tree_k_nearest_search #(
    parameter int MAX_POINTS     = kdk_pkg::DEF_MAX_POINTS,
    parameter int MAX_NEIGHBOURS = kdk_pkg::DEF_MAX_NEIGHBOURS,
    parameter int COORD_BITS     = kdk_pkg::DEF_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  kdk_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kdk_pkg::rsp_t rsp
);

    localparam int C      = COORD_BITS;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int HCW    = $clog2(MAX_NEIGHBOURS + 1);
    localparam int HIW    = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int HX_W   = HCW + 1;
    localparam int SQ_W   = 2 * C;
    localparam int DIST_W = SQ_W + 2;
    localparam int RAD_W  = (DIST_W > kdk_pkg::DIST_OUT_W) ? DIST_W : kdk_pkg::DIST_OUT_W;
    localparam int SD     = CNT_W;
    localparam int SPW    = $clog2(SD + 1);
    localparam int STW    = $clog2(SD);
    localparam int PT_W   = 3 * C + kdk_pkg::FIELD_W;
    localparam int HE_W   = kdk_pkg::FIELD_W + RAD_W;

    // control and walk registers
    kdk_pkg::state_t  state_reg, state_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [HCW-1:0]   hits_reg, hits_next;
    logic [HCW-1:0]   want_reg, want_next;
    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [C-1:0]     qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic [IDX_W-1:0] cur_n_reg, cur_n_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [1:0]       axis_reg, axis_next;
    logic             gpos_reg, gpos_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [HIW-1:0]   hcur_reg, hcur_next;
    logic [HIW-1:0]   sub_reg, sub_next;
    logic [HIW-1:0]   k_reg, k_next;
    logic [HE_W-1:0]  cv_reg, cv_next;
    logic [HE_W-1:0]  lv_reg, lv_next;
    logic             rok_reg, rok_next;
    logic             mode_rt_reg, mode_rt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    kdk_pkg::rsp_t    rsp_reg, rsp_next;

    // walk stack of suspended nodes
    logic [IDX_W-1:0]  stk_n_reg    [SD];
    logic [CNT_W-1:0]  stk_size_reg [SD];
    logic [1:0]        stk_axis_reg [SD];
    kdk_pkg::phase_t   stk_phase_reg[SD];
    logic              stk_gpos_reg [SD];
    logic [SQ_W-1:0]   stk_gap2_reg [SD];

    // memories and shared units
    logic             pt_we, pt_re;
    logic [IDX_W-1:0] pt_waddr;
    logic [PT_W-1:0]  pt_wdata, pt_rd;
    logic             hp_we, hp_re;
    logic [HIW-1:0]   hp_waddr, hp_raddr;
    logic [HE_W-1:0]  hp_wdata, hp_rd;
    logic signed [C:0] sq_in;
    logic [SQ_W-1:0]  sq_out;
    logic [CNT_W-1:0] left, right;

    // decoded fields
    logic [C-1:0]     px, py, pz, qc, pc;
    logic [15:0]      pid;
    logic [C+15:0]    wx, wy, wz;
    logic [C-1:0]     ex, ey, ez;
    logic signed [C:0] gap_diff;
    logic             accept;
    logic             slot_free;
    logic [STW-1:0]   top_idx, push_idx;
    logic [IDX_W-1:0] tn;
    logic [CNT_W-1:0] tsize;
    logic [1:0]       taxis, nx;
    kdk_pkg::phase_t  tphase;
    logic             tgpos;
    logic [SQ_W-1:0]  tgap2;
    logic             close;
    logic             res_go_l, res_go_r, res_pop;
    kdk_pkg::phase_t  res_phase;
    kdk_pkg::state_t  ret_state;
    logic [HX_W-1:0]  lx, rx;
    logic             dist_hit;
    logic [RAD_W-1:0] lv_d, rv_d, cv_d;
    logic             pick_r, move;
    logic [HCW-1:0]   half;

    kdk_ram #(
        .DEPTH  (MAX_POINTS),
        .DATA_W (PT_W),
        .ADDR_W (IDX_W)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (pt_we),
        .wr_addr (pt_waddr),
        .wr_data (pt_wdata),
        .rd_en   (pt_re),
        .rd_addr (cur_n_reg),
        .rd_data (pt_rd)
    );

    kdk_ram #(
        .DEPTH  (MAX_NEIGHBOURS),
        .DATA_W (HE_W),
        .ADDR_W (HIW)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (hp_we),
        .wr_addr (hp_waddr),
        .wr_data (hp_wdata),
        .rd_en   (hp_re),
        .rd_addr (hp_raddr),
        .rd_data (hp_rd)
    );

    kdk_sq_unit #(
        .COORD_BITS (C)
    ) u_sq (
        .clk    (clk),
        .diff   (sq_in),
        .sq_reg (sq_out)
    );

    kdk_split #(
        .CNT_W (CNT_W)
    ) u_split (
        .size  (tsize),
        .left  (left),
        .right (right)
    );

    assign cmd_stall = (state_reg != kdk_pkg::S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // coordinates taken from bit COORD_BITS-1 of the field, sign extended later
    assign wx = {{C{1'b0}}, cmd.x_coord};
    assign wy = {{C{1'b0}}, cmd.y_coord};
    assign wz = {{C{1'b0}}, cmd.z_coord};
    assign ex = wx[C-1:0];
    assign ey = wy[C-1:0];
    assign ez = wz[C-1:0];

    assign px  = pt_rd[PT_W-1 -: C];
    assign py  = pt_rd[PT_W-1-C -: C];
    assign pz  = pt_rd[PT_W-1-2*C -: C];
    assign pid = pt_rd[kdk_pkg::FIELD_W-1:0];

    // axis gap of the current node
    always_comb
    begin
        case (axis_reg)
            kdk_pkg::AXIS_X:
            begin
                qc = qx_reg;
                pc = px;
            end
            kdk_pkg::AXIS_Y:
            begin
                qc = qy_reg;
                pc = py;
            end
            default:
            begin
                qc = qz_reg;
                pc = pz;
            end
        endcase
    end
    assign gap_diff = $signed({qc[C-1], qc}) - $signed({pc[C-1], pc});

    // top of the walk stack
    assign top_idx  = STW'(sp_reg - SPW'(1));
    assign push_idx = STW'(sp_reg);
    assign tn       = stk_n_reg[top_idx];
    assign tsize    = stk_size_reg[top_idx];
    assign taxis    = stk_axis_reg[top_idx];
    assign tphase   = stk_phase_reg[top_idx];
    assign tgpos    = stk_gpos_reg[top_idx];
    assign tgap2    = stk_gap2_reg[top_idx];
    assign nx       = (taxis == kdk_pkg::AXIS_Z) ? kdk_pkg::AXIS_X : taxis + 2'd1;
    assign close    = RAD_W'(tgap2) < rad_reg;

    // which child to visit on resume: near side first, far side only when
    // the axis gap is still inside the current radius
    always_comb
    begin
        res_go_l  = 1'b0;
        res_go_r  = 1'b0;
        res_pop   = 1'b0;
        res_phase = kdk_pkg::PH_DONE;
        case (tphase)
            kdk_pkg::PH_FIRST:
            begin
                res_phase = kdk_pkg::PH_SECOND;
                if (tgpos)
                begin
                    res_go_r = (right != '0);
                end
                else
                begin
                    res_go_l = 1'b1;
                end
            end
            kdk_pkg::PH_SECOND:
            begin
                res_phase = kdk_pkg::PH_DONE;
                if (tgpos)
                begin
                    res_go_l = close;
                end
                else
                begin
                    res_go_r = (right != '0) && close;
                end
            end
            default:
            begin
                res_pop = 1'b1;
            end
        endcase
    end

    assign ret_state = (sp_reg == '0) ? kdk_pkg::S_EMIT : kdk_pkg::S_RESUME;
    assign dist_hit  = RAD_W'(dist_reg) < rad_reg;

    // heap sift helpers
    assign lx   = (HX_W'(hcur_reg) << 1) + HX_W'(1);
    assign rx   = lx + HX_W'(1);
    assign lv_d = lv_reg[RAD_W-1:0];
    assign rv_d = hp_rd[RAD_W-1:0];
    assign cv_d = cv_reg[RAD_W-1:0];
    assign half = want_reg >> 1;

    // child choice: heap build keeps ties on the left and moves only on a
    // strictly larger child; top replacement prefers the right child on ties
    // and moves unless the new distance is strictly larger
    always_comb
    begin
        if (mode_rt_reg)
        begin
            pick_r = rok_reg && !(lv_d > rv_d);
            move   = pick_r ? !(cv_d > rv_d) : !(cv_d > lv_d);
        end
        else
        begin
            if (lv_d > cv_d)
            begin
                pick_r = rok_reg && (rv_d > lv_d);
                move   = 1'b1;
            end
            else
            begin
                pick_r = rok_reg && (rv_d > cv_d);
                move   = pick_r;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kdk_pkg::S_IDLE:
            begin
                if (accept && (cmd.operation == kdk_pkg::OP_QUERY))
                begin
                    if ((total_reg != '0) && (cmd.want_count != '0))
                    begin
                        state_next = kdk_pkg::S_NODE;
                    end
                    else
                    begin
                        state_next = kdk_pkg::S_EMIT;
                    end
                end
            end
            kdk_pkg::S_NODE:
            begin
                state_next = kdk_pkg::S_NODE_RD;
            end
            kdk_pkg::S_NODE_RD:
            begin
                state_next = (size_reg > CNT_W'(1)) ? kdk_pkg::S_GAP : kdk_pkg::S_D0;
            end
            kdk_pkg::S_GAP:
            begin
                state_next = kdk_pkg::S_RESUME;
            end
            kdk_pkg::S_RESUME:
            begin
                if (res_go_l || res_go_r)
                begin
                    state_next = kdk_pkg::S_NODE;
                end
                else if (res_pop)
                begin
                    state_next = kdk_pkg::S_DRD;
                end
            end
            kdk_pkg::S_DRD:
            begin
                state_next = kdk_pkg::S_D0;
            end
            kdk_pkg::S_D0:
            begin
                state_next = kdk_pkg::S_D1;
            end
            kdk_pkg::S_D1:
            begin
                state_next = kdk_pkg::S_D2;
            end
            kdk_pkg::S_D2:
            begin
                state_next = kdk_pkg::S_D3;
            end
            kdk_pkg::S_D3:
            begin
                state_next = kdk_pkg::S_HIT;
            end
            kdk_pkg::S_HIT:
            begin
                if (!dist_hit)
                begin
                    state_next = ret_state;
                end
                else if (hits_reg < want_reg)
                begin
                    if (HCW'(hits_reg + HCW'(1)) == want_reg)
                    begin
                        state_next = kdk_pkg::S_MH_INIT;
                    end
                    else
                    begin
                        state_next = ret_state;
                    end
                end
                else
                begin
                    state_next = kdk_pkg::S_SF_L;
                end
            end
            kdk_pkg::S_MH_INIT:
            begin
                state_next = (half == '0) ? kdk_pkg::S_TOPRD : kdk_pkg::S_MH_SUB;
            end
            kdk_pkg::S_MH_SUB:
            begin
                state_next = kdk_pkg::S_MH_V;
            end
            kdk_pkg::S_MH_V:
            begin
                state_next = kdk_pkg::S_SF_L;
            end
            kdk_pkg::S_SF_L:
            begin
                state_next = (lx >= HX_W'(hits_reg)) ? kdk_pkg::S_SF_END : kdk_pkg::S_SF_R;
            end
            kdk_pkg::S_SF_R:
            begin
                state_next = kdk_pkg::S_SF_C;
            end
            kdk_pkg::S_SF_C:
            begin
                state_next = move ? kdk_pkg::S_SF_L : kdk_pkg::S_SF_END;
            end
            kdk_pkg::S_SF_END:
            begin
                if (mode_rt_reg || (sub_reg == '0))
                begin
                    state_next = kdk_pkg::S_TOPRD;
                end
                else
                begin
                    state_next = kdk_pkg::S_MH_SUB;
                end
            end
            kdk_pkg::S_TOPRD:
            begin
                state_next = kdk_pkg::S_TOP;
            end
            kdk_pkg::S_TOP:
            begin
                state_next = ret_state;
            end
            kdk_pkg::S_EMIT:
            begin
                state_next = (hits_reg == '0) ? kdk_pkg::S_EM_NONE : kdk_pkg::S_EM_RD;
            end
            kdk_pkg::S_EM_NONE:
            begin
                if (slot_free)
                begin
                    state_next = kdk_pkg::S_IDLE;
                end
            end
            kdk_pkg::S_EM_RD:
            begin
                state_next = kdk_pkg::S_EM_LD;
            end
            kdk_pkg::S_EM_LD:
            begin
                if (slot_free)
                begin
                    if (HCW'(k_reg) + HCW'(1) == hits_reg)
                    begin
                        state_next = kdk_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = kdk_pkg::S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = kdk_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        sp_next        = sp_reg;
        total_next     = total_reg;
        hits_next      = hits_reg;
        want_next      = want_reg;
        rad_next       = rad_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        cur_n_next     = cur_n_reg;
        size_next      = size_reg;
        axis_next      = axis_reg;
        gpos_next      = gpos_reg;
        acc_next       = acc_reg;
        dist_next      = dist_reg;
        hcur_next      = hcur_reg;
        sub_next       = sub_reg;
        k_next         = k_reg;
        cv_next        = cv_reg;
        lv_next        = lv_reg;
        rok_next       = rok_reg;
        mode_rt_next   = mode_rt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pt_we          = 1'b0;
        pt_waddr       = IDX_W'(total_reg);
        pt_wdata       = {ex, ey, ez, cmd.point_id};
        pt_re          = 1'b0;
        hp_we          = 1'b0;
        hp_waddr       = hcur_reg;
        hp_wdata       = cv_reg;
        hp_re          = 1'b0;
        hp_raddr       = '0;
        sq_in          = '0;

        case (state_reg)
            kdk_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        kdk_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                        end
                        kdk_pkg::OP_APPEND:
                        begin
                            if (total_reg < CNT_W'(MAX_POINTS))
                            begin
                                pt_we      = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                        kdk_pkg::OP_QUERY:
                        begin
                            if (int'(cmd.want_count) > MAX_NEIGHBOURS)
                            begin
                                want_next = HCW'(MAX_NEIGHBOURS);
                            end
                            else
                            begin
                                want_next = HCW'(cmd.want_count);
                            end
                            rad_next   = RAD_W'(cmd.search_radius_sq);
                            hits_next  = '0;
                            qx_next    = ex;
                            qy_next    = ey;
                            qz_next    = ez;
                            cur_n_next = '0;
                            size_next  = total_reg;
                            axis_next  = kdk_pkg::AXIS_X;
                            sp_next    = '0;
                        end
                        default:
                        begin
                            total_next = total_reg;
                        end
                    endcase
                end
            end
            kdk_pkg::S_NODE:
            begin
                pt_re = 1'b1;
            end
            kdk_pkg::S_NODE_RD:
            begin
                sq_in     = gap_diff;
                gpos_next = !gap_diff[C] && (gap_diff != '0);
            end
            kdk_pkg::S_GAP:
            begin
                sp_next = sp_reg + SPW'(1);
            end
            kdk_pkg::S_RESUME:
            begin
                if (res_go_l)
                begin
                    cur_n_next = IDX_W'(CNT_W'(tn) + CNT_W'(1));
                    size_next  = left;
                    axis_next  = nx;
                end
                else if (res_go_r)
                begin
                    cur_n_next = IDX_W'(CNT_W'(tn) + left + CNT_W'(1));
                    size_next  = right;
                    axis_next  = nx;
                end
                else if (res_pop)
                begin
                    cur_n_next = tn;
                    sp_next    = sp_reg - SPW'(1);
                end
            end
            kdk_pkg::S_DRD:
            begin
                pt_re = 1'b1;
            end
            kdk_pkg::S_D0:
            begin
                sq_in = $signed({qx_reg[C-1], qx_reg}) - $signed({px[C-1], px});
            end
            kdk_pkg::S_D1:
            begin
                acc_next = DIST_W'(sq_out);
                sq_in    = $signed({qy_reg[C-1], qy_reg}) - $signed({py[C-1], py});
            end
            kdk_pkg::S_D2:
            begin
                acc_next = acc_reg + DIST_W'(sq_out);
                sq_in    = $signed({qz_reg[C-1], qz_reg}) - $signed({pz[C-1], pz});
            end
            kdk_pkg::S_D3:
            begin
                dist_next = acc_reg + DIST_W'(sq_out);
            end
            kdk_pkg::S_HIT:
            begin
                if (dist_hit)
                begin
                    if (hits_reg < want_reg)
                    begin
                        // still filling: plain append at the end of the list
                        hp_we     = 1'b1;
                        hp_waddr  = HIW'(hits_reg);
                        hp_wdata  = {pid, RAD_W'(dist_reg)};
                        hits_next = hits_reg + HCW'(1);
                    end
                    else
                    begin
                        // full: new hit replaces the heap top
                        cv_next      = {pid, RAD_W'(dist_reg)};
                        hcur_next    = '0;
                        mode_rt_next = 1'b1;
                    end
                end
            end
            kdk_pkg::S_MH_INIT:
            begin
                sub_next     = HIW'(half - HCW'(1));
                mode_rt_next = 1'b0;
            end
            kdk_pkg::S_MH_SUB:
            begin
                hp_re     = 1'b1;
                hp_raddr  = sub_reg;
                hcur_next = sub_reg;
            end
            kdk_pkg::S_MH_V:
            begin
                cv_next = hp_rd;
            end
            kdk_pkg::S_SF_L:
            begin
                hp_re    = 1'b1;
                hp_raddr = HIW'(lx);
            end
            kdk_pkg::S_SF_R:
            begin
                lv_next  = hp_rd;
                rok_next = rx < HX_W'(hits_reg);
                hp_re    = rx < HX_W'(hits_reg);
                hp_raddr = HIW'(rx);
            end
            kdk_pkg::S_SF_C:
            begin
                if (move)
                begin
                    hp_we     = 1'b1;
                    hp_waddr  = hcur_reg;
                    hp_wdata  = pick_r ? hp_rd : lv_reg;
                    hcur_next = pick_r ? HIW'(rx) : HIW'(lx);
                end
            end
            kdk_pkg::S_SF_END:
            begin
                hp_we    = 1'b1;
                hp_waddr = hcur_reg;
                hp_wdata = cv_reg;
                if (!mode_rt_reg && (sub_reg != '0))
                begin
                    sub_next = sub_reg - HIW'(1);
                end
            end
            kdk_pkg::S_TOPRD:
            begin
                hp_re    = 1'b1;
                hp_raddr = '0;
            end
            kdk_pkg::S_TOP:
            begin
                rad_next = hp_rd[RAD_W-1:0];
            end
            kdk_pkg::S_EMIT:
            begin
                k_next = '0;
            end
            kdk_pkg::S_EM_NONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.none_found  = 1'b1;
                    rsp_next.last_result = 1'b1;
                end
            end
            kdk_pkg::S_EM_RD:
            begin
                hp_re    = 1'b1;
                hp_raddr = k_reg;
            end
            kdk_pkg::S_EM_LD:
            begin
                if (slot_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.neighbour_id    = hp_rd[HE_W-1 -: kdk_pkg::FIELD_W];
                    rsp_next.distance_sq     = hp_rd[kdk_pkg::DIST_OUT_W-1:0];
                    rsp_next.final_radius_sq = rad_reg[kdk_pkg::DIST_OUT_W-1:0];
                    rsp_next.found_total     = kdk_pkg::COUNT_OUT_W'(hits_reg);
                    rsp_next.none_found      = 1'b0;
                    rsp_next.last_result     = (HCW'(k_reg) + HCW'(1) == hits_reg);
                    k_next                   = k_reg + HIW'(1);
                end
            end
            default:
            begin
                sq_in = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kdk_pkg::S_IDLE;
            sp_reg        <= '0;
            total_reg     <= '0;
            hits_reg      <= '0;
            want_reg      <= '0;
            rad_reg       <= '0;
            mode_rt_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            total_reg     <= total_next;
            hits_reg      <= hits_next;
            want_reg      <= want_next;
            rad_reg       <= rad_next;
            mode_rt_reg   <= mode_rt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        qz_reg    <= qz_next;
        cur_n_reg <= cur_n_next;
        size_reg  <= size_next;
        axis_reg  <= axis_next;
        gpos_reg  <= gpos_next;
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
        hcur_reg  <= hcur_next;
        sub_reg   <= sub_next;
        k_reg     <= k_next;
        cv_reg    <= cv_next;
        lv_reg    <= lv_next;
        rok_reg   <= rok_next;
        rsp_reg   <= rsp_next;
    end

    // stack push on a split node, phase update on resume
    always_ff @(posedge clk)
    begin
        if (state_reg == kdk_pkg::S_GAP)
        begin
            stk_n_reg[push_idx]     <= cur_n_reg;
            stk_size_reg[push_idx]  <= size_reg;
            stk_axis_reg[push_idx]  <= axis_reg;
            stk_phase_reg[push_idx] <= kdk_pkg::PH_FIRST;
            stk_gpos_reg[push_idx]  <= gpos_reg;
            stk_gap2_reg[push_idx]  <= sq_out;
        end
        else if ((state_reg == kdk_pkg::S_RESUME) && !res_pop)
        begin
            stk_phase_reg[top_idx] <= res_phase;
        end
    end

endmodule

// ----- hw/rtl/kdk_ram.sv -----
// kdk_ram: single-port-write, single-port-read memory with registered read data
// no dependencies; holds the point store and the neighbour heap

module kdk_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 8,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/kdk_sq_unit.sv -----
// kdk_sq_unit: shared squarer for coordinate differences, result registered
// no dependencies; serves axis gaps and the three distance terms in turn

module kdk_sq_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic signed [COORD_BITS:0] diff,
    output logic [2*COORD_BITS-1:0]   sq_reg
);

    logic [COORD_BITS:0]   mag_wide;
    logic [COORD_BITS-1:0] mag;

    // magnitude of a difference of two coordinates fits in COORD_BITS
    assign mag_wide = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    assign mag      = mag_wide[COORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        sq_reg <= mag * mag;
    end

endmodule

// ----- hw/rtl/kdk_split.sv -----
// kdk_split: left and right subtree sizes of an implicit kd-tree node
// no dependencies; used by the walk sequencer in the top level

module kdk_split #(
    parameter int CNT_W = 11
) (
    input  logic [CNT_W-1:0] size,
    output logic [CNT_W-1:0] left,
    output logic [CNT_W-1:0] right
);

    logic [CNT_W-1:0] pow;
    logic             full_tree;

    assign full_tree = ((size + CNT_W'(1)) & size) == '0;

    always_comb
    begin
        pow = '0;
        // highest set bit wins
        for (int j = 0; j < CNT_W; j++)
        begin
            if (size[j])
            begin
                pow = CNT_W'(1) << j;
            end
        end
        if (full_tree)
        begin
            left  = size >> 1;
            right = size >> 1;
        end
        else if (size == CNT_W'(2))
        begin
            left  = CNT_W'(1);
            right = '0;
        end
        else
        begin
            left  = pow - CNT_W'(1);
            right = size - pow;
        end
    end

endmodule

// ----- dv/kdk_search_checker.sv -----
// kdk_search_checker: watches the command and result channels of the kd-tree search block,
// predicts every result beat of each query and compares; depends on kdk_pkg

module kdk_search_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  kdk_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  kdk_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_count
);

    localparam int NPTS  = kdk_pkg::DEF_MAX_POINTS;
    localparam int NNEIB = kdk_pkg::DEF_MAX_NEIGHBOURS;

    logic signed [17:0] pts [NPTS][3];
    logic [15:0]        ids [NPTS];
    int                 npts;
    logic [15:0]        hp_id [NNEIB];
    logic [34:0]        hp_d  [NNEIB];
    logic [34:0]        radius;
    logic signed [17:0] qp [3];
    int                 hits;
    int                 want;
    kdk_pkg::rsp_t      expected_beats [$];

    assign pending_count = expected_beats.size();

    function automatic logic [34:0] sqr(logic signed [17:0] d);
        logic signed [35:0] p;
        p = d * d;
        return p[34:0];
    endfunction

    function automatic void hswap(int a, int b);
        logic [15:0] ti;
        logic [34:0] td;
        ti = hp_id[a];
        td = hp_d[a];
        hp_id[a] = hp_id[b];
        hp_d[a] = hp_d[b];
        hp_id[b] = ti;
        hp_d[b] = td;
    endfunction

    function automatic void heapify(int hs);
        int last;
        int cur;
        int l;
        int r;
        int big;
        last = hs / 2 - 1;
        for (int s = last; s >= 0; s--)
        begin
            cur = s;
            while (cur <= last)
            begin
                l = 2 * cur + 1;
                r = 2 * cur + 2;
                big = cur;
                if (l < hs && hp_d[l] > hp_d[big]) big = l;
                if (r < hs && hp_d[r] > hp_d[big]) big = r;
                if (big == cur) break;
                hswap(big, cur);
                cur = big;
            end
        end
    endfunction

    function automatic void sift_in(int hs, logic [15:0] id, logic [34:0] d);
        int cur;
        int l;
        int r;
        int big;
        cur = 0;
        forever
        begin
            l = 2 * cur + 1;
            r = 2 * cur + 2;
            if (l >= hs) break;
            if (r >= hs || hp_d[l] > hp_d[r]) big = l;
            else big = r;
            if (d > hp_d[big]) break;
            hswap(big, cur);
            cur = big;
        end
        hp_d[cur] = d;
        hp_id[cur] = id;
    endfunction

    function automatic void visit(int n, int size, int axis);
        logic signed [17:0] gap;
        logic [34:0]        g2;
        logic [34:0]        d;
        int                 lsz;
        int                 rsz;
        int                 i;
        int                 nx;
        if (n >= npts || axis >= 3) return;
        if (size > 1)
        begin
            gap = qp[axis] - pts[n][axis];
            g2 = sqr(gap);
            nx = (axis + 1) % 3;
            if (((size + 1) & size) == 0)
            begin
                lsz = size >> 1;
                rsz = size >> 1;
            end
            else if (size == 2)
            begin
                lsz = 1;
                rsz = 0;
            end
            else
            begin
                i = 0;
                for (int c = size; c > 1; c >>= 1) i++;
                lsz = (1 << i) - 1;
                rsz = size - lsz - 1;
            end
            if (gap > 0)
            begin
                if (rsz != 0) visit(n + lsz + 1, rsz, nx);
                if (g2 < radius) visit(n + 1, lsz, nx);
            end
            else
            begin
                visit(n + 1, lsz, nx);
                if (rsz != 0 && g2 < radius) visit(n + lsz + 1, rsz, nx);
            end
        end
        d = sqr(pts[n][0] - qp[0]) + sqr(pts[n][1] - qp[1]) + sqr(pts[n][2] - qp[2]);
        if (d < radius)
        begin
            if (hits < want)
            begin
                hp_id[hits] = ids[n];
                hp_d[hits] = d;
                hits++;
                if (hits == want)
                begin
                    heapify(hits);
                    radius = hp_d[0];
                end
            end
            else
            begin
                sift_in(hits, ids[n], d);
                radius = hp_d[0];
            end
        end
    endfunction

    function automatic void predict_query(kdk_pkg::cmd_t c);
        kdk_pkg::rsp_t r;
        want = (c.want_count > NNEIB) ? NNEIB : int'(c.want_count);
        radius = {1'b0, c.search_radius_sq};
        hits = 0;
        qp[0] = 18'(c.x_coord);
        qp[1] = 18'(c.y_coord);
        qp[2] = 18'(c.z_coord);
        if (npts > 0 && want > 0) visit(0, npts, 0);
        if (hits == 0)
        begin
            r = '0;
            r.none_found = 1'b1;
            r.last_result = 1'b1;
            expected_beats = {expected_beats, r};
            return;
        end
        for (int k = 0; k < hits; k++)
        begin
            r.neighbour_id = hp_id[k];
            r.distance_sq = hp_d[k][33:0];
            r.final_radius_sq = radius[33:0];
            r.found_total = hits[5:0];
            r.none_found = 1'b0;
            r.last_result = (k + 1 == hits);
            expected_beats = {expected_beats, r};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kdk_pkg::rsp_t e;
        if (!rst_n)
        begin
            npts = 0;
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", rsp);
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (e !== rsp)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p actual %p", e, rsp);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd.operation)
                    kdk_pkg::OP_CLEAR:
                        npts = 0;
                    kdk_pkg::OP_APPEND:
                        if (npts < NPTS)
                        begin
                            pts[npts][0] = 18'(cmd.x_coord);
                            pts[npts][1] = 18'(cmd.y_coord);
                            pts[npts][2] = 18'(cmd.z_coord);
                            ids[npts] = cmd.point_id;
                            npts++;
                        end
                    kdk_pkg::OP_QUERY:
                        predict_query(cmd);
                    default:
                        ;
                endcase
            end
        end
    end
endmodule

// ----- dv/kd_tree_k_nearest_search_test.sv -----
// kd_tree_k_nearest_search_test: stimulus and verdict for the kd-tree k-nearest search block
// depends on kdk_pkg, the block's rtl and kdk_search_checker

module kd_tree_k_nearest_search_test;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     ITEM_GOAL   = 480;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    kdk_pkg::cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    kdk_pkg::rsp_t rsp;
    int   fail_count;
    int   pending_count;
    longint cycles = 0;
    int   burst_left;
    int   sent_count;

    kd_tree_k_nearest_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    kdk_search_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit: catches a hung walk or a lost beat
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kd_tree_k_nearest_search_test: FAIL");
            $finish;
        end
    end

    // receiver stall pattern: calm stretches, short bursts, and heavy stalling
    always @(posedge clk)
    begin
        int mode;
        mode = int'((cycles / 700) % 3);
        if (!rst_n) rsp_stall <= 1'b0;
        else if (mode == 0) rsp_stall <= 1'b0;
        else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
        else rsp_stall <= ($urandom_range(0, 9) < 6);
    end

    // random coordinate, mostly small so that hits happen, sometimes extreme
    function automatic logic [15:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        return 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    function automatic logic [33:0] rand_radius();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 34'h3_ffff_ffff;
        if (sel == 1) return {$urandom, 2'($urandom)};
        if (sel == 2) return 34'($urandom_range(0, 4));
        return 34'($urandom_range(0, 200000));
    endfunction

    function automatic kdk_pkg::cmd_t make_cmd(kdk_pkg::op_t op, logic [15:0] x,
                                               logic [15:0] y, logic [15:0] z,
                                               logic [15:0] id, logic [5:0] k,
                                               logic [33:0] r2);
        kdk_pkg::cmd_t c;
        c.operation = op;
        c.x_coord = x;
        c.y_coord = y;
        c.z_coord = z;
        c.point_id = id;
        c.want_count = k;
        c.search_radius_sq = r2;
        return c;
    endfunction

    // one command beat with the sender's burst and gap behavior; valid drops
    // only when a gap really follows
    task automatic send_beat(kdk_pkg::cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_query(logic [5:0] k, logic [33:0] r2);
        send_beat(make_cmd(kdk_pkg::OP_QUERY, rand_coord(), rand_coord(), rand_coord(),
                           16'($urandom), k, r2));
    endtask

    // load a fresh random store of n points
    task automatic load_store(int n);
        send_beat(make_cmd(kdk_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 6'($urandom), 34'($urandom)));
        for (int i = 0; i < n; i++)
            send_beat(make_cmd(kdk_pkg::OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
                               16'($urandom), 6'($urandom), 34'($urandom)));
    endtask

    initial
    begin
        burst_left = 0;
        sent_count = 0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, unknown op, extremes, want zero and oversized
        send_query(6'd5, 34'h3_ffff_ffff);
        send_beat(make_cmd(kdk_pkg::op_t'(2'd3), 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                           6'h3f, 34'h3_ffff_ffff));
        send_beat(make_cmd(kdk_pkg::OP_APPEND, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff,
                           6'd0, 34'd0));
        send_beat(make_cmd(kdk_pkg::OP_APPEND, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                           6'd0, 34'd0));
        send_beat(make_cmd(kdk_pkg::OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h1234,
                           6'd0, 34'd0));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'd0, 6'd3,
                           34'h3_ffff_ffff));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 6'h3f,
                           34'h3_ffff_ffff));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd0, 6'd0,
                           34'h3_ffff_ffff));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd0, 6'd1,
                           34'd0));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd0, 6'd1,
                           34'd1));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h0001, 16'h0000, 16'h0000, 16'd0, 6'd2,
                           34'd1));
        send_beat(make_cmd(kdk_pkg::OP_QUERY, 16'h0001, 16'h0000, 16'h0000, 16'd0, 6'd2,
                           34'd2));
        // clear then query gives none
        load_store(0);
        send_query(6'd4, 34'h3_ffff_ffff);

        // random phases: mostly modest stores with several queries each
        while (sent_count < ITEM_GOAL)
        begin
            load_store($urandom_range(0, 9) == 0 ? $urandom_range(30, 45)
                                                 : $urandom_range(1, 20));
            repeat ($urandom_range(2, 8))
            begin
                send_query(6'($urandom), rand_radius());
            end
            if ($urandom_range(0, 3) == 0)
                send_beat(make_cmd(kdk_pkg::op_t'(2'd3), 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 6'($urandom),
                                   34'($urandom)));
        end
        cmd_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("kd_tree_k_nearest_search_test: PASS");
        else
            $display("kd_tree_k_nearest_search_test: FAIL");
        $finish;
    end
endmodule
